// ----- sv/fosq_pkg.sv -----
`default_nettype none

package fosq_pkg;

  // field widths fixed by the interface
  localparam int unsigned ValueW = 8;
  localparam int unsigned CountW = 6;

  localparam int unsigned DefaultDepth = 32;

  typedef enum logic [1:0] {
    ReqPush  = 2'd0,
    ReqPop   = 2'd1,
    ReqClear = 2'd2
  } req_e;

  typedef struct packed {
    req_e              req_type;
    logic [ValueW-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic [ValueW-1:0] popped_value;
    logic              pop_valid;
    logic              overflow;
    logic [CountW-1:0] entry_count;
    logic              is_empty;
  } out_t;

  // write data source for the entry store
  typedef enum logic [1:0] {
    WrSrcIn,
    WrSrcValue,
    WrSrcRdata
  } wr_src_e;

  // logical read position, relative to the head
  typedef enum logic [1:0] {
    RdHead,
    RdLast,
    RdPosM2
  } rd_sel_e;

  typedef struct packed {
    logic    wr_en;
    wr_src_e wr_src;
    logic    wr_at_pos;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    latch_value;
    logic    set_pos;
    logic    dec_pos;
    logic    inc_count;
    logic    pop_commit;
    logic    clear;
    logic    emit;
    logic    emit_pop;
    logic    emit_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic sorted;
    logic count_zero;
    logic full;
    logic pos_one;
    logic rd_gt;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/fifo_or_sorted_priority_queue.sv -----
// sequence: a fifo push or one into an empty store, a dropped push, a clear, a pop on empty
// and the unused code register their result from idle; a pop reads the head, StPop emits it;
// a sorted push reads the last entry, StSort moves larger entries back, StSort or StPlace writes the value
// throughput: one request at a time, next one taken once the controller is idle and the
// result register is free; sorted insert walks the store one entry per cycle (ram read port)
// reset: async active low, store empty, fifo mode, store contents undefined until written
`default_nettype none

module fifo_or_sorted_priority_queue #(
  parameter int unsigned DEPTH = fosq_pkg::DefaultDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // request channel
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire fosq_pkg::in_t  in_data_i,
  // result channel
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output fosq_pkg::out_t      out_data_o,
  // mode register, writing it also empties the store
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_wdata_i
);

  import fosq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller decodes the request and sequences the sorted insert
  fosq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_data_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: ring-addressed entry store, count, head, insert position, result register
  fosq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- sv/fosq_ram.sv -----
`default_nettype none

module fosq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/fosq_ctrl.sv -----
`default_nettype none

module fosq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire fosq_pkg::req_e       req_i,
  input  wire fosq_pkg::dp_status_t status_i,
  output fosq_pkg::dp_cmd_t         cmd_o
);

  import fosq_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StPop,
    StSort,
    StPlace
  } state_e;

  state_e state_q, state_d;
  logic   ready;

  assign ready      = (state_q == StIdle) && status_i.out_free;
  assign in_stall_o = !ready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_src = WrSrcIn;
    cmd_o.rd_sel = RdHead;
    case (state_q)
      StIdle: begin
        if (in_valid_i && ready) begin
          case (req_i)
            ReqPush: begin
              if (status_i.full) begin
                cmd_o.emit     = 1'b1;
                cmd_o.emit_ovf = 1'b1;
              end else if (!status_i.sorted || status_i.count_zero) begin
                // append at the tail
                cmd_o.wr_en     = 1'b1;
                cmd_o.wr_src    = WrSrcIn;
                cmd_o.inc_count = 1'b1;
                cmd_o.emit      = 1'b1;
              end else begin
                cmd_o.latch_value = 1'b1;
                cmd_o.set_pos     = 1'b1;
                cmd_o.rd_en       = 1'b1;
                cmd_o.rd_sel      = RdLast;
                state_d           = StSort;
              end
            end
            ReqPop: begin
              if (status_i.count_zero) begin
                cmd_o.emit = 1'b1;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RdHead;
                state_d      = StPop;
              end
            end
            ReqClear: begin
              cmd_o.clear = 1'b1;
              cmd_o.emit  = 1'b1;
            end
            default: begin
              cmd_o.emit = 1'b1;
            end
          endcase
        end
      end
      StPop: begin
        cmd_o.pop_commit = 1'b1;
        cmd_o.emit       = 1'b1;
        cmd_o.emit_pop   = 1'b1;
        state_d          = StIdle;
      end
      StSort: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_at_pos = 1'b1;
        if (status_i.rd_gt) begin
          // shift the larger entry one place back
          cmd_o.wr_src  = WrSrcRdata;
          cmd_o.dec_pos = 1'b1;
          if (status_i.pos_one) begin
            state_d = StPlace;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RdPosM2;
          end
        end else begin
          cmd_o.wr_src    = WrSrcValue;
          cmd_o.inc_count = 1'b1;
          cmd_o.emit      = 1'b1;
          state_d         = StIdle;
        end
      end
      StPlace: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_at_pos = 1'b1;
        cmd_o.wr_src    = WrSrcValue;
        cmd_o.inc_count = 1'b1;
        cmd_o.emit      = 1'b1;
        state_d         = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/fosq_dp.sv -----
`default_nettype none

module fosq_dp #(
  parameter int unsigned DEPTH = fosq_pkg::DefaultDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fosq_pkg::in_t                 in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  input  wire fosq_pkg::dp_cmd_t             cmd_i,
  output fosq_pkg::dp_status_t               status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output fosq_pkg::out_t                     out_data_o
);

  import fosq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic              mode_q;
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [ValueW-1:0] value_q;
  out_t              out_q;
  logic              out_valid_q;

  logic [IdxW-1:0]   wr_log, rd_log, wr_addr, rd_addr;
  logic [ValueW-1:0] wr_data, rdata;
  logic [CntW-1:0]   rd_lin;
  logic [CntW+CountW-1:0] count_ext;

  // ring position: head plus logical offset, wrapped once
  function automatic logic [IdxW-1:0] wrap(input logic [IdxW-1:0] base,
                                           input logic [IdxW-1:0] ofs);
    logic [IdxW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (IdxW + 1)'(DEPTH)) begin
      s = s - (IdxW + 1)'(DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  always_comb begin
    case (cmd_i.rd_sel)
      RdHead:  rd_lin = '0;
      RdLast:  rd_lin = count_q - CntW'(1);
      RdPosM2: rd_lin = pos_q - CntW'(2);
      default: rd_lin = '0;
    endcase
    case (cmd_i.wr_src)
      WrSrcIn:    wr_data = in_data_i.push_value;
      WrSrcValue: wr_data = value_q;
      WrSrcRdata: wr_data = rdata;
      default:    wr_data = in_data_i.push_value;
    endcase
  end

  assign rd_log  = rd_lin[IdxW-1:0];
  assign wr_log  = cmd_i.wr_at_pos ? pos_q[IdxW-1:0] : count_q[IdxW-1:0];
  assign rd_addr = wrap(head_q, rd_log);
  assign wr_addr = wrap(head_q, wr_log);

  fosq_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    pos_d   = pos_q;
    if (cmd_i.clear || cfg_we_i) begin
      count_d = '0;
    end else if (cmd_i.inc_count) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop_commit) begin
      count_d = count_q - CntW'(1);
    end
    if (cmd_i.pop_commit) begin
      head_d = wrap(head_q, IdxW'(1));
    end
    if (cmd_i.set_pos) begin
      pos_d = count_q;
    end else if (cmd_i.dec_pos) begin
      pos_d = pos_q - CntW'(1);
    end
  end

  assign count_ext = {{CountW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.latch_value) begin
      value_q <= in_data_i.push_value;
    end
    if (cmd_i.emit) begin
      out_q.popped_value <= cmd_i.emit_pop ? rdata : '0;
      out_q.pop_valid    <= cmd_i.emit_pop;
      out_q.overflow     <= cmd_i.emit_ovf;
      out_q.entry_count  <= count_ext[CountW-1:0];
      out_q.is_empty     <= (count_d == '0);
    end
  end

  assign status_o.sorted     = mode_q;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.full       = (count_q == CntW'(DEPTH));
  assign status_o.pos_one    = (pos_q == CntW'(1));
  assign status_o.rd_gt      = (rdata > value_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
